// File: rtl/nub_evt_pkg.sv
// types, codes and constants shared by the nub pointer report block
`default_nettype none
package nub_evt_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE          = 4'd0,
    REG_MOUSE_GAIN    = 4'd1,
    REG_SCROLL_GAIN_X = 4'd2,
    REG_SCROLL_GAIN_Y = 4'd3,
    REG_SCROLL_PERIOD = 4'd4,
    REG_BUTTON_THR_X  = 4'd5,
    REG_BUTTON_THR_Y  = 4'd6,
    REG_BUTTON_DELAY  = 4'd7
  } cfg_reg_t;

  // operating modes, also used as report kinds
  localparam logic [1:0] MODE_ABS    = 2'd0;
  localparam logic [1:0] MODE_MOUSE  = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;
  localparam logic [1:0] MODE_BUTTON = 2'd3;

  typedef enum logic [2:0] {
    DIR_CENTER = 3'd0,
    DIR_UP     = 3'd1,
    DIR_RIGHT  = 3'd2,
    DIR_DOWN   = 3'd3,
    DIR_LEFT   = 3'd4
  } dir_t;

  localparam logic [5:0] SCROLL_COUNT_MAX = 6'd63;
  localparam logic [7:0] STABLE_COUNT_MAX = 8'd255;
  localparam logic [2:0] CLICK_STAGE_MAX  = 3'd7;

  localparam logic [1:0]         RST_MODE          = MODE_ABS;
  localparam logic signed [15:0] RST_MOUSE_GAIN    = 16'sd435;
  localparam logic signed [15:0] RST_SCROLL_GAIN   = 16'sd20;
  localparam logic [5:0]         RST_SCROLL_PERIOD = 6'd13;
  localparam logic [5:0]         RST_BUTTON_THR_X  = 6'd20;
  localparam logic [5:0]         RST_BUTTON_THR_Y  = 6'd26;
  localparam logic [7:0]         RST_BUTTON_DELAY  = 8'd1;

  typedef struct packed {
    logic              sample_valid;
    logic signed [7:0] raw_rel_x;
    logic signed [7:0] raw_rel_y;
    logic signed [7:0] raw_abs_x;
    logic signed [7:0] raw_abs_y;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         report_kind;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic               button_left;
    logic               button_middle;
    logic               button_right;
  } out_rep_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] mouse_gain;
    logic signed [15:0] scroll_gain_x;
    logic signed [15:0] scroll_gain_y;
    logic [5:0]         scroll_period;
    logic [5:0]         button_threshold_x;
    logic [5:0]         button_threshold_y;
    logic [7:0]         button_delay;
  } cfg_regs_t;

  typedef struct packed {
    logic [5:0] scroll_count;
    dir_t       previous_direction;
    dir_t       active_direction;
    logic [7:0] stable_count;
    logic [2:0] click_stage;
  } nub_state_t;

endpackage
`default_nettype wire

// File: rtl/nub_evt_chan_if.sv
// valid/ready channel carrying one payload of a chosen type
`default_nettype none
interface nub_evt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/nub_evt_core.sv
// per-sample report logic: classifies, scales and works out the next state
`default_nettype none
module nub_evt_core (
  input  nub_evt_pkg::cfg_regs_t  cfg,
  input  nub_evt_pkg::nub_state_t st,
  input  nub_evt_pkg::in_req_t    req,
  output nub_evt_pkg::nub_state_t st_nxt,
  output nub_evt_pkg::out_rep_t   rep,
  output logic                    emit
);
  import nub_evt_pkg::*;

  logic signed [8:0]  rx, ry, ax, ay, neg_ry, neg_ay;
  logic signed [8:0]  thr_x, thr_y;
  logic signed [8:0]  mul_op_x, mul_op_y;
  logic signed [15:0] mul_gain_x, mul_gain_y;
  logic signed [24:0] prod_x, prod_y, adj_x, adj_y;
  logic signed [15:0] quot_x, quot_y;
  logic [5:0]         scroll_inc;
  dir_t               pos_raw, pos;
  logic [7:0]         stable_nxt;
  logic [2:0]         click_nxt;

  // a failed read counts as all zero
  assign rx = req.sample_valid ? 9'(req.raw_rel_x) : '0;
  assign ry = req.sample_valid ? 9'(req.raw_rel_y) : '0;
  assign ax = req.sample_valid ? 9'(req.raw_abs_x) : '0;
  assign ay = req.sample_valid ? 9'(req.raw_abs_y) : '0;
  assign neg_ry = -ry;
  assign neg_ay = -ay;

  // two multipliers shared between mouse and scroll modes
  assign mul_op_x   = (cfg.mode == MODE_MOUSE) ? rx : ax;
  assign mul_op_y   = (cfg.mode == MODE_MOUSE) ? neg_ry : ay;
  assign mul_gain_x = (cfg.mode == MODE_MOUSE) ? cfg.mouse_gain : cfg.scroll_gain_x;
  assign mul_gain_y = (cfg.mode == MODE_MOUSE) ? cfg.mouse_gain : cfg.scroll_gain_y;
  assign prod_x = 25'(mul_op_x) * 25'(mul_gain_x);
  assign prod_y = 25'(mul_op_y) * 25'(mul_gain_y);

  // divide by 256 rounding toward zero: bias negatives by 255 first
  assign adj_x  = prod_x + {17'd0, {8{prod_x[24]}}};
  assign adj_y  = prod_y + {17'd0, {8{prod_y[24]}}};
  assign quot_x = adj_x[23:8];
  assign quot_y = adj_y[23:8];

  assign scroll_inc = (st.scroll_count < SCROLL_COUNT_MAX) ?
                      st.scroll_count + 6'd1 : st.scroll_count;

  assign thr_x = $signed({3'b000, cfg.button_threshold_x});
  assign thr_y = $signed({3'b000, cfg.button_threshold_y});

  always_comb begin
    if (ax >= thr_x) begin
      pos_raw = DIR_RIGHT;
    end else if (ax <= -thr_x) begin
      pos_raw = DIR_LEFT;
    end else if (ay >= thr_y) begin
      pos_raw = DIR_UP;
    end else if (ay <= -thr_y) begin
      pos_raw = DIR_DOWN;
    end else begin
      pos_raw = DIR_CENTER;
    end
  end

  always_comb begin
    if (pos_raw != st.previous_direction) begin
      stable_nxt = '0;
    end else if (st.stable_count < STABLE_COUNT_MAX) begin
      stable_nxt = st.stable_count + 8'd1;
    end else begin
      stable_nxt = st.stable_count;
    end
    pos = (stable_nxt < cfg.button_delay) ? st.active_direction : pos_raw;
    if (pos != DIR_UP) begin
      click_nxt = '0;
    end else if (st.click_stage < CLICK_STAGE_MAX) begin
      click_nxt = st.click_stage + 3'd1;
    end else begin
      click_nxt = st.click_stage;
    end
  end

  always_comb begin
    st_nxt = st;
    emit   = 1'b1;
    rep    = '0;
    rep.report_kind = cfg.mode;
    case (cfg.mode)
      MODE_ABS: begin
        rep.value_x = {{4{ax[8]}}, ax, 3'b000};
        rep.value_y = {{4{neg_ay[8]}}, neg_ay, 3'b000};
      end
      MODE_MOUSE: begin
        rep.value_x = quot_x;
        rep.value_y = quot_y;
      end
      MODE_SCROLL: begin
        if (scroll_inc < cfg.scroll_period) begin
          st_nxt.scroll_count = scroll_inc;
          emit = 1'b0;
        end else begin
          st_nxt.scroll_count = '0;
        end
        rep.value_x = quot_x;
        rep.value_y = quot_y;
      end
      MODE_BUTTON: begin
        if (!req.sample_valid) begin
          // release everything, debounce history is kept
          st_nxt.active_direction = DIR_CENTER;
        end else begin
          st_nxt.previous_direction = pos_raw;
          st_nxt.stable_count       = stable_nxt;
          st_nxt.click_stage        = click_nxt;
          st_nxt.active_direction   = pos;
          case (pos)
            DIR_UP: begin
              rep.button_left = (click_nxt == 3'd1) || (click_nxt == 3'd2) ||
                                (click_nxt == 3'd5) || (click_nxt == 3'd6);
            end
            DIR_RIGHT: rep.button_right  = 1'b1;
            DIR_DOWN:  rep.button_middle = 1'b1;
            DIR_LEFT:  rep.button_left   = 1'b1;
            default:   rep.button_left   = 1'b0;
          endcase
        end
      end
      default: emit = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/nub_sample_to_pointer_events.sv
// nub sample to pointer report, top level
// the sample stage holds each accepted request, the report stage its report
// throughput: one request per cycle while out_ch is ready, set by the single sample and report stages
// scroll mode drops the report for all but one request in scroll_period
// reset (rst_n low, synchronous) restores register defaults, clears all
// counters and directions to center and empties both stages
`default_nettype none
module nub_sample_to_pointer_events (
  input  logic           clk,
  input  logic           rst_n,
  nub_evt_chan_if.sink   in_ch,
  nub_evt_chan_if.source out_ch,
  nub_evt_chan_if.sink   cfg_ch
);
  import nub_evt_pkg::*;

  cfg_regs_t  cfg_r;
  nub_state_t st_r;
  nub_state_t st_nxt;
  nub_state_t st_upd_nxt;
  in_req_t    s1_req_r;
  logic       s1_valid_r;
  out_rep_t   out_rep_r;
  out_rep_t   rep_nxt;
  logic       out_valid_r;
  logic       emit_nxt;
  logic       adv;
  logic       mode_wr;

  // sample stage moves on whenever the report stage is free or draining
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_rep_r;
  assign mode_wr      = cfg_ch.valid && cfg_ch.ready && (cfg_ch.data.index == REG_MODE);

  nub_evt_core u_core (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (s1_req_r),
    .st_nxt (st_nxt),
    .rep    (rep_nxt),
    .emit   (emit_nxt)
  );

  // a mode write recentres the active direction
  always_comb begin
    st_upd_nxt = adv ? st_nxt : st_r;
    if (mode_wr) begin
      st_upd_nxt.active_direction = DIR_CENTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= emit_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r <= in_ch.data;
    end
    if (adv && emit_nxt) begin
      out_rep_r <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode               <= RST_MODE;
      cfg_r.mouse_gain         <= RST_MOUSE_GAIN;
      cfg_r.scroll_gain_x      <= RST_SCROLL_GAIN;
      cfg_r.scroll_gain_y      <= RST_SCROLL_GAIN;
      cfg_r.scroll_period      <= RST_SCROLL_PERIOD;
      cfg_r.button_threshold_x <= RST_BUTTON_THR_X;
      cfg_r.button_threshold_y <= RST_BUTTON_THR_Y;
      cfg_r.button_delay       <= RST_BUTTON_DELAY;
      st_r.scroll_count        <= '0;
      st_r.previous_direction  <= DIR_CENTER;
      st_r.active_direction    <= DIR_CENTER;
      st_r.stable_count        <= '0;
      st_r.click_stage         <= '0;
    end else begin
      st_r <= st_upd_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_MODE:          cfg_r.mode               <= cfg_ch.data.value[1:0];
          REG_MOUSE_GAIN:    cfg_r.mouse_gain         <= $signed(cfg_ch.data.value);
          REG_SCROLL_GAIN_X: cfg_r.scroll_gain_x      <= $signed(cfg_ch.data.value);
          REG_SCROLL_GAIN_Y: cfg_r.scroll_gain_y      <= $signed(cfg_ch.data.value);
          REG_SCROLL_PERIOD: cfg_r.scroll_period      <= cfg_ch.data.value[5:0];
          REG_BUTTON_THR_X:  cfg_r.button_threshold_x <= cfg_ch.data.value[5:0];
          REG_BUTTON_THR_Y:  cfg_r.button_threshold_y <= cfg_ch.data.value[5:0];
          REG_BUTTON_DELAY:  cfg_r.button_delay       <= cfg_ch.data.value[7:0];
          default:           cfg_r.mode               <= cfg_r.mode;
        endcase
      end
    end
  end

  // button reports carry no motion, and at most one button is held
  a_button_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rep_r.report_kind == MODE_BUTTON) |->
      (out_rep_r.value_x == 16'sd0) && (out_rep_r.value_y == 16'sd0))
    else $error("button report with motion");

  a_one_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      $onehot0({out_rep_r.button_left, out_rep_r.button_middle, out_rep_r.button_right}))
    else $error("more than one button pressed");

  a_motion_no_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rep_r.report_kind != MODE_BUTTON) |->
      !(out_rep_r.button_left || out_rep_r.button_middle || out_rep_r.button_right))
    else $error("buttons set outside button mode");

  a_mode_write_centres: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready && (cfg_ch.data.index == REG_MODE) |=>
      (st_r.active_direction == DIR_CENTER))
    else $error("mode write left a direction active");

endmodule
`default_nettype wire
